>>> hdl/ectc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ectc_pkg
// Shared widths, types and constants for the epoch seconds to calendar path.
// ----------------------------------------------------------------------------
package ectc_pkg;

  localparam int YEAR_W   = 16;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // 86400 = 2^7 * 675: the low bits split off, the odd part is divided
  localparam int          DAY_LOW_BITS = 7;
  localparam int unsigned DAY_ODD_DIV  = 675;
  localparam int          DAY_REM_W    = 10;
  localparam int          TOD_W        = DAY_REM_W + DAY_LOW_BITS;

  localparam int unsigned ERA_DAYS = 146097;
  localparam int          DOE_W    = 18;
  localparam int          ERA_W    = 16;

  // seconds in one 400-year era, and the shift of the day count to 0000-03-01
  localparam logic [63:0] ERA_SECONDS   = 64'd12622780800;
  localparam logic [63:0] MARCH_SECONDS = 64'd62162035200;

  typedef logic [DOE_W-1:0]          doe_t;
  typedef logic [TOD_W-1:0]          tod_t;
  typedef logic [ERA_W-1:0]          era_t;
  typedef logic signed [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0]        month_t;
  typedef logic [DAY_W-1:0]          day_t;
  typedef logic [HOUR_W-1:0]         hour_t;
  typedef logic [MINUTE_W-1:0]       minute_t;
  typedef logic [SECOND_W-1:0]       second_t;

  // first day of each march-based month, counted from 1 march
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> hdl/ectc_cdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ectc_cdiv
// Pipelined long division by a constant, one digit of KB bits per stage.
// ----------------------------------------------------------------------------
module ectc_cdiv #(
  parameter int          DW      = 35,
  parameter int unsigned DIVISOR = 675,
  parameter int          DB      = 10,
  parameter int          KB      = 16,
  parameter int          QW      = 35,
  parameter int          SW      = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_vld,
  output logic          up_rdy,
  input  logic [DW-1:0] up_dividend,
  input  logic [SW-1:0] up_side,
  output logic          dn_vld,
  input  logic          dn_rdy,
  output logic [QW-1:0] dn_quot,
  output logic [DB-1:0] dn_rem,
  output logic [SW-1:0] dn_side
);

  localparam int NS = (DW + KB - 1) / KB;
  localparam int PW = NS * KB;
  localparam int XB = DB + KB;
  localparam longint unsigned RECIP = (64'd1 << XB) / DIVISOR;
  localparam int MB = $clog2(RECIP + 1);
  localparam int PB = XB + MB;
  localparam logic [XB-1:0] DIV_X   = XB'(DIVISOR);
  localparam logic [MB-1:0] RECIP_M = MB'(RECIP);

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  logic [NS-1:0] vld_in;
  logic [DB-1:0] rem_r    [NS];
  logic [PW-1:0] num_r    [NS];
  logic [QW-1:0] quot_r   [NS];
  logic [SW-1:0] side_r   [NS];
  logic [DB-1:0] rem_nxt  [NS];
  logic [PW-1:0] num_nxt  [NS];
  logic [QW-1:0] quot_nxt [NS];
  logic [SW-1:0] side_nxt [NS];

  // a stage takes a request when empty or when the one after it moves on
  always_comb begin
    rdy[NS] = dn_rdy;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin : digit_logic
    logic [DB-1:0] rem_in;
    logic [PW-1:0] num_in;
    logic [QW-1:0] quot_in;
    logic [XB-1:0] x;
    logic [PB-1:0] prod;
    logic [KB-1:0] q0;
    logic [KB-1:0] q;
    logic [XB-1:0] r0;
    logic [XB-1:0] r;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        vld_in[k]   = up_vld;
        rem_in      = '0;
        num_in      = PW'(up_dividend);
        quot_in     = '0;
        side_nxt[k] = up_side;
      end else begin
        vld_in[k]   = v_r[k-1];
        rem_in      = rem_r[k-1];
        num_in      = num_r[k-1];
        quot_in     = quot_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      x    = {rem_in, num_in[PW-1 -: KB]};
      // reciprocal estimate is exact or one short
      prod = PB'(x) * PB'(RECIP_M);
      q0   = prod[XB +: KB];
      r0   = x - XB'(q0) * DIV_X;
      if (r0 >= DIV_X) begin
        q = q0 + KB'(1);
        r = r0 - DIV_X;
      end else begin
        q = q0;
        r = r0;
      end
      rem_nxt[k]  = DB'(r);
      num_nxt[k]  = num_in << KB;
      quot_nxt[k] = QW'({quot_in, q});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= vld_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k] && vld_in[k]) begin
        rem_r[k]  <= rem_nxt[k];
        num_r[k]  <= num_nxt[k];
        quot_r[k] <= quot_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign up_rdy  = rdy[0];
  assign dn_vld  = v_r[NS-1];
  assign dn_quot = quot_r[NS-1];
  assign dn_rem  = rem_r[NS-1];
  assign dn_side = side_r[NS-1];

endmodule

>>> hdl/ectc_civil.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ectc_civil
// Day of era and time of day to year, month, day, hour, minute and second.
// ----------------------------------------------------------------------------
module ectc_civil (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_vld,
  output logic              up_rdy,
  input  ectc_pkg::era_t    up_era,
  input  ectc_pkg::doe_t    up_doe,
  input  ectc_pkg::tod_t    up_tod,
  output logic              dn_vld,
  input  logic              dn_rdy,
  output ectc_pkg::year_t   dn_year,
  output ectc_pkg::month_t  dn_month,
  output ectc_pkg::day_t    dn_day,
  output ectc_pkg::hour_t   dn_hour,
  output ectc_pkg::minute_t dn_minute,
  output ectc_pkg::second_t dn_second
);

  import ectc_pkg::*;

  logic [3:0] v_r;
  logic [4:0] rdy;
  logic [3:0] vld_in;

  // stage 1: year-of-era numerator, hour
  logic [DOE_W-1:0] s1_n_r,   s1_n_nxt;
  doe_t             s1_doe_r;
  logic [15:0]      s1_yb_r,  s1_yb_nxt;
  hour_t            s1_hour_r, s1_hour_nxt;
  logic [11:0]      s1_hrem_r, s1_hrem_nxt;
  // stage 2: year of era, minute, second
  logic [8:0]       s2_yoe_r, s2_yoe_nxt;
  doe_t             s2_doe_r;
  logic [15:0]      s2_yb_r;
  hour_t            s2_hour_r;
  minute_t          s2_min_r, s2_min_nxt;
  second_t          s2_sec_r, s2_sec_nxt;
  // stage 3: day of year
  logic [8:0]       s3_doy_r, s3_doy_nxt;
  logic [8:0]       s3_yoe_r;
  logic [15:0]      s3_yb_r;
  hour_t            s3_hour_r;
  minute_t          s3_min_r;
  second_t          s3_sec_r;
  // stage 4: result register
  year_t            s4_year_r,  s4_year_nxt;
  month_t           s4_month_r, s4_month_nxt;
  day_t             s4_day_r,   s4_day_nxt;
  hour_t            s4_hour_r;
  minute_t          s4_min_r;
  second_t          s4_sec_r;

  always_comb begin
    vld_in = {v_r[2:0], up_vld};
    rdy[4] = dn_rdy;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin : stage1_logic
    logic [25:0]      a_prod;
    logic [7:0]       a0;
    logic [7:0]       a;
    logic [DOE_W-1:0] a_rem;
    logic [2:0]       cent;
    logic             last_day;
    logic [21:0]      h_prod;
    hour_t            h0;
    logic [TOD_W-1:0] h_rem;
    // doe / 1460 by reciprocal, corrected once
    a_prod = 26'(up_doe) * 26'(8'd179);
    a0     = a_prod[18 +: 8];
    a_rem  = up_doe - DOE_W'(a0) * DOE_W'(1460);
    a      = (a_rem >= DOE_W'(1460)) ? a0 + 8'd1 : a0;
    // doe / 36524 and doe / 146096 take few values
    cent = 3'(up_doe >= DOE_W'(36524)) + 3'(up_doe >= DOE_W'(73048))
         + 3'(up_doe >= DOE_W'(109572)) + 3'(up_doe >= DOE_W'(146096));
    last_day = (up_doe == DOE_W'(146096));
    s1_n_nxt = up_doe - DOE_W'(a) + DOE_W'(cent) - DOE_W'(last_day);
    s1_yb_nxt = 16'(up_era * 16'd400);
    h_prod = 22'(up_tod) * 22'(6'd36);
    h0     = h_prod[17 +: HOUR_W];
    h_rem  = up_tod - TOD_W'(h0) * TOD_W'(3600);
    if (h_rem >= TOD_W'(3600)) begin
      s1_hour_nxt = h0 + hour_t'(1);
      s1_hrem_nxt = 12'(h_rem - TOD_W'(3600));
    end else begin
      s1_hour_nxt = h0;
      s1_hrem_nxt = 12'(h_rem);
    end
  end

  always_comb begin : stage2_logic
    logic [27:0]      y_prod;
    logic [8:0]       y0;
    logic [DOE_W-1:0] y_rem;
    logic [18:0]      m_prod;
    minute_t          m0;
    logic [11:0]      m_rem;
    y_prod = 28'(s1_n_r) * 28'(10'd718);
    y0     = y_prod[18 +: 9];
    y_rem  = s1_n_r - DOE_W'(y0) * DOE_W'(365);
    s2_yoe_nxt = (y_rem >= DOE_W'(365)) ? y0 + 9'd1 : y0;
    m_prod = 19'(s1_hrem_r) * 19'(7'd68);
    m0     = m_prod[12 +: MINUTE_W];
    m_rem  = s1_hrem_r - 12'(m0) * 12'(60);
    if (m_rem >= 12'(60)) begin
      s2_min_nxt = m0 + minute_t'(1);
      s2_sec_nxt = SECOND_W'(m_rem - 12'(60));
    end else begin
      s2_min_nxt = m0;
      s2_sec_nxt = SECOND_W'(m_rem);
    end
  end

  always_comb begin : stage3_logic
    logic [1:0]       yc;
    logic [DOE_W-1:0] base;
    yc   = 2'(s2_yoe_r >= 9'd100) + 2'(s2_yoe_r >= 9'd200) + 2'(s2_yoe_r >= 9'd300);
    base = DOE_W'(s2_yoe_r) * DOE_W'(365) + DOE_W'(s2_yoe_r >> 2) - DOE_W'(yc);
    s3_doy_nxt = 9'(s2_doe_r - base);
  end

  always_comb begin : stage4_logic
    logic [10:0] t5;
    logic [14:0] mp_prod;
    logic [3:0]  mp0;
    logic [3:0]  mp;
    logic [10:0] mp_rem;
    t5      = 11'(s3_doy_r) * 11'(5) + 11'(2);
    mp_prod = 15'(t5) * 15'(4'd13);
    mp0     = mp_prod[11 +: 4];
    mp_rem  = t5 - 11'(mp0) * 11'(153);
    mp      = (mp_rem >= 11'(153)) ? mp0 + 4'd1 : mp0;
    s4_day_nxt   = DAY_W'(s3_doy_r - month_start(mp) + 9'd1);
    // march-based month back to january-based
    s4_month_nxt = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    s4_year_nxt  = year_t'(16'(s3_yoe_r) + s3_yb_r + 16'(s4_month_nxt <= 4'd2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (rdy[k]) begin
          v_r[k] <= vld_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && vld_in[0]) begin
      s1_n_r    <= s1_n_nxt;
      s1_doe_r  <= up_doe;
      s1_yb_r   <= s1_yb_nxt;
      s1_hour_r <= s1_hour_nxt;
      s1_hrem_r <= s1_hrem_nxt;
    end
    if (rdy[1] && vld_in[1]) begin
      s2_yoe_r  <= s2_yoe_nxt;
      s2_doe_r  <= s1_doe_r;
      s2_yb_r   <= s1_yb_r;
      s2_hour_r <= s1_hour_r;
      s2_min_r  <= s2_min_nxt;
      s2_sec_r  <= s2_sec_nxt;
    end
    if (rdy[2] && vld_in[2]) begin
      s3_doy_r  <= s3_doy_nxt;
      s3_yoe_r  <= s2_yoe_r;
      s3_yb_r   <= s2_yb_r;
      s3_hour_r <= s2_hour_r;
      s3_min_r  <= s2_min_r;
      s3_sec_r  <= s2_sec_r;
    end
    if (rdy[3] && vld_in[3]) begin
      s4_year_r  <= s4_year_nxt;
      s4_month_r <= s4_month_nxt;
      s4_day_r   <= s4_day_nxt;
      s4_hour_r  <= s3_hour_r;
      s4_min_r   <= s3_min_r;
      s4_sec_r   <= s3_sec_r;
    end
  end

  assign up_rdy    = rdy[0];
  assign dn_vld    = v_r[3];
  assign dn_year   = s4_year_r;
  assign dn_month  = s4_month_r;
  assign dn_day    = s4_day_r;
  assign dn_hour   = s4_hour_r;
  assign dn_minute = s4_min_r;
  assign dn_second = s4_sec_r;

endmodule

>>> hdl/epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Signed seconds since 1970-01-01 00:00:00 UTC to proleptic Gregorian date
// and time of day.
//
//   channel  handshake            payload
//   in_      in_valid / in_stall  in_epoch_seconds
//   out_     out_valid/ out_stall out_year, out_month, out_day,
//                                 out_hour, out_minute, out_second
//
// One request per cycle sustained while out_stall stays low. The divide-by-675
// and divide-by-146097 pipelines have ceil((UW-7)/16) and ceil((UW-7)/12)
// digit stages. Reset clears only the stage valid flags.
// A stall on out_ holds the full stages; empty stages still fill, so in_stall
// rises only once every stage holds a request.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top #(
  parameter int SECONDS_WIDTH = 40
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SECONDS_WIDTH-1:0] in_epoch_seconds,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ectc_pkg::year_t                 out_year,
  output ectc_pkg::month_t                out_month,
  output ectc_pkg::day_t                  out_day,
  output ectc_pkg::hour_t                 out_hour,
  output ectc_pkg::minute_t               out_minute,
  output ectc_pkg::second_t               out_second
);

  import ectc_pkg::*;

  localparam int UW  = (SECONDS_WIDTH + 2 > 38) ? SECONDS_WIDTH + 2 : 38;
  localparam int DW1 = UW - DAY_LOW_BITS;

  // bias by whole eras so the count is never negative, plus the march shift
  localparam logic [UW-1:0] ERA_SEC    = UW'(ERA_SECONDS);
  localparam logic [UW-1:0] HALF_RANGE = UW'(1) << (SECONDS_WIDTH - 1);
  localparam logic [UW-1:0] ERA_BIAS   = (HALF_RANGE + ERA_SEC - UW'(1)) / ERA_SEC;
  localparam logic [UW-1:0] SEC_BIAS   = ERA_BIAS * ERA_SEC + UW'(MARCH_SECONDS);
  localparam era_t          ERA_BIAS16 = ERA_W'(ERA_BIAS);

  logic          v_r;
  logic [UW-1:0] secs_r;
  logic [UW-1:0] secs_nxt;
  logic          rdy0;

  logic             d1_rdy;
  logic             d1_vld;
  logic [DW1-1:0]   d1_quot;
  logic [DAY_REM_W-1:0]    d1_rem;
  logic [DAY_LOW_BITS-1:0] d1_side;

  logic  d2_rdy;
  logic  d2_vld;
  era_t  d2_quot;
  doe_t  d2_rem;
  tod_t  d2_side;
  logic  civ_rdy;

  assign secs_nxt = UW'(in_epoch_seconds) + SEC_BIAS;
  assign rdy0     = !v_r || d1_rdy;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy0) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      secs_r <= secs_nxt;
    end
  end

  ectc_cdiv #(
    .DW      (DW1),
    .DIVISOR (DAY_ODD_DIV),
    .DB      (DAY_REM_W),
    .KB      (16),
    .QW      (DW1),
    .SW      (DAY_LOW_BITS)
  ) u_day_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_vld      (v_r),
    .up_rdy      (d1_rdy),
    .up_dividend (secs_r[UW-1:DAY_LOW_BITS]),
    .up_side     (secs_r[DAY_LOW_BITS-1:0]),
    .dn_vld      (d1_vld),
    .dn_rdy      (d2_rdy),
    .dn_quot     (d1_quot),
    .dn_rem      (d1_rem),
    .dn_side     (d1_side)
  );

  ectc_cdiv #(
    .DW      (DW1),
    .DIVISOR (ERA_DAYS),
    .DB      (DOE_W),
    .KB      (12),
    .QW      (ERA_W),
    .SW      (TOD_W)
  ) u_era_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_vld      (d1_vld),
    .up_rdy      (d2_rdy),
    .up_dividend (d1_quot),
    .up_side     ({d1_rem, d1_side}),
    .dn_vld      (d2_vld),
    .dn_rdy      (civ_rdy),
    .dn_quot     (d2_quot),
    .dn_rem      (d2_rem),
    .dn_side     (d2_side)
  );

  ectc_civil u_civil (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_vld    (d2_vld),
    .up_rdy    (civ_rdy),
    .up_era    (d2_quot - ERA_BIAS16),
    .up_doe    (d2_rem),
    .up_tod    (d2_side),
    .dn_vld    (out_valid),
    .dn_rdy    (!out_stall),
    .dn_year   (out_year),
    .dn_month  (out_month),
    .dn_day    (out_day),
    .dn_hour   (out_hour),
    .dn_minute (out_minute),
    .dn_second (out_second)
  );

  // the input side stalls only while the input register is occupied
  assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> v_r)
    else $error("input stalled with an empty input register");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day >= 5'd1))
    else $error("month or day out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_second <= 6'd59))
    else $error("time of day out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_month == 4'd2) |-> out_day <= 5'd29)
    else $error("february longer than 29 days");

endmodule

>>> test/tb_epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_top
// Drives signed epoch seconds into the converter and checks every civil date
// and time of day against an in-bench calendar predictor. It covers directed
// day, leap and era boundaries, the extremes of the 40-bit range, random
// requests with random gaps on both sides, a long receiver hold-off and
// drain pauses.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_top;

  import ectc_pkg::*;

  localparam int     SECONDS_W      = 40;
  localparam int     LATENCY        = 11;
  localparam int     WATCHDOG_LIMIT = 5000;
  localparam longint SECS_PER_DAY   = 86400;
  localparam longint MARCH0_SHIFT   = 719468;
  localparam longint ERA_DAY_COUNT  = 146097;
  localparam longint ERA_SECS       = 64'sd12622780800;
  localparam longint MARCH0_SECS    = -64'sd62162035200;

  typedef struct packed {
    year_t   year;
    month_t  month;
    day_t    day;
    hour_t   hour;
    minute_t minute;
    second_t second;
  } calendar_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [SECONDS_W-1:0] in_epoch_seconds;
  logic                        out_valid;
  logic                        out_stall;
  year_t                       out_year;
  month_t                      out_month;
  day_t                        out_day;
  hour_t                       out_hour;
  minute_t                     out_minute;
  second_t                     out_second;

  calendar_t pending_dates[$];
  calendar_t head_date;
  int        mismatch_count;
  int        idle_cycles = 0;
  int        stall_left;
  int        hold_req;
  bit        tx_idle_en;
  bit        rx_idle_en;

  epoch_seconds_to_calendar_top #(
    .SECONDS_WIDTH(SECONDS_W)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_epoch_seconds(in_epoch_seconds),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_quot(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic calendar_t civil_from_seconds(input logic signed [SECONDS_W-1:0] secs);
    longint    t, days, tod, era, doe, yoe, doy, mp, dd, mo, yr;
    calendar_t c;
    t    = secs;
    days = floor_quot(t, SECS_PER_DAY);
    tod  = t - days * SECS_PER_DAY;
    days = days + MARCH0_SHIFT;
    era  = floor_quot(days, ERA_DAY_COUNT);
    doe  = days - era * ERA_DAY_COUNT;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    dd   = doy - (153 * mp + 2) / 5 + 1;
    mo   = (mp < 10) ? mp + 3 : mp - 9;
    yr   = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
    c.year   = yr[YEAR_W-1:0];
    c.month  = mo[MONTH_W-1:0];
    c.day    = dd[DAY_W-1:0];
    c.hour   = hour_t'(tod / 3600);
    c.minute = minute_t'((tod / 60) % 60);
    c.second = second_t'(tod % 60);
    return c;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(12, 40);
  endfunction

  function automatic logic signed [SECONDS_W-1:0] random_seconds();
    logic [63:0] raw;
    longint      v;
    int unsigned kind;
    raw  = {$urandom, $urandom};
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      v = longint'($signed(raw[SECONDS_W-1:0]));
    end else if (kind < 60) begin
      // within a few centuries of 1970
      v = longint'($signed(raw[33:0]));
    end else if (kind < 80) begin
      v = longint'($signed(raw[22:0])) * SECS_PER_DAY + longint'($urandom_range(0, 2)) - 1;
    end else if (kind < 92) begin
      // around the start of a 400-year era, leap day included
      v = MARCH0_SECS + longint'($signed(raw[5:0])) * ERA_SECS
          + longint'($urandom_range(0, 345600)) - 172800;
    end else if (raw[63]) begin
      v = (64'sd1 <<< (SECONDS_W - 1)) - 1 - longint'($urandom_range(0, 200000));
    end else begin
      v = -(64'sd1 <<< (SECONDS_W - 1)) + longint'($urandom_range(0, 200000));
    end
    return v[SECONDS_W-1:0];
  endfunction

  function automatic bit tx_gap_pick(output int gap);
    gap = tx_idle_en ? random_gap() : 0;
    return gap > 0;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // called at a falling edge; returns at a falling edge with valid still high
  // when no gap follows, so back-to-back requests never drop valid
  task automatic send_seconds(input logic signed [SECONDS_W-1:0] secs);
    int gap;
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_dates.push_back(civil_from_seconds(secs));
    @(negedge clk);
    if (tx_gap_pick(gap)) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_dates.size() != 0) begin
      @(negedge clk);
    end
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic test_directed_boundaries();
    longint points[22];
    points = '{
      0, -1, 1, 86399, 86400, -86400, -86401,
      946684799, 946684800,             // turn of the millennium
      951782400, 951868799,             // 2000-02-29, leap day of a century
      4107456000, 4107542400,           // 2100-02-28 then 2100-03-01, no leap day
      2147483647, 253402300799,
      -62135596800, -62167219200,
      MARCH0_SECS, MARCH0_SECS - 1,     // era start and the last second before it
      MARCH0_SECS + ERA_SECS,
      (64'sd1 <<< (SECONDS_W - 1)) - 1, // largest count
      -(64'sd1 <<< (SECONDS_W - 1))     // smallest count
    };
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    foreach (points[i]) begin
      send_seconds(points[i][SECONDS_W-1:0]);
    end
    release_input();
  endtask

  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (100) send_seconds(random_seconds());
    release_input();
  endtask

  task automatic test_random_spread();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (900) send_seconds(random_seconds());
    release_input();
  endtask

  // receiver holds off while requests keep coming, so the pipe fills up
  task automatic test_receiver_hold();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req   = 120;
    repeat (60) send_seconds(random_seconds());
    release_input();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (4) begin
      repeat (60) send_seconds(random_seconds());
      release_input();
      wait_drained();
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end else if (stall_left == 0 && rx_idle_en) begin
        stall_left = random_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result, year", out_year, 0);
      end else begin
        head_date = pending_dates.pop_front();
        if (out_year !== head_date.year) begin
          report_mismatch("year", out_year, head_date.year);
        end
        if (out_month !== head_date.month) begin
          report_mismatch("month", out_month, head_date.month);
        end
        if (out_day !== head_date.day) begin
          report_mismatch("day", out_day, head_date.day);
        end
        if (out_hour !== head_date.hour) begin
          report_mismatch("hour", out_hour, head_date.hour);
        end
        if (out_minute !== head_date.minute) begin
          report_mismatch("minute", out_minute, head_date.minute);
        end
        if (out_second !== head_date.second) begin
          report_mismatch("second", out_second, head_date.second);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_epoch_seconds_to_calendar_top: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_epoch_seconds = '0;
    mismatch_count   = 0;
    hold_req         = 0;
    tx_idle_en       = 1'b0;
    rx_idle_en       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_boundaries();
    test_back_to_back();
    test_random_spread();
    test_receiver_hold();
    test_drain_pause();
    wait_drained();
    if (pending_dates.size() != 0) begin
      report_mismatch("results never arrived", 0, pending_dates.size());
    end
    if (mismatch_count == 0) begin
      $display("tb_epoch_seconds_to_calendar_top: PASS");
    end else begin
      $display("tb_epoch_seconds_to_calendar_top: FAIL");
    end
    $finish;
  end

endmodule
